### src/chm_pkg.sv
package chm_pkg;

    localparam int MAX_BUCKETS    = 64;
    localparam int NODE_POOL_SIZE = 256;
    localparam int BKT_W          = $clog2(MAX_BUCKETS);
    localparam int NODE_W         = $clog2(NODE_POOL_SIZE);
    localparam int LINK_W         = NODE_W + 1;
    localparam int CNT_W          = $clog2(NODE_POOL_SIZE + 1);

    localparam logic [LINK_W-1:0] NIL_NODE = LINK_W'(NODE_POOL_SIZE);

    localparam logic [63:0] FNV_BASIS = 64'hCBF29CE484222325;
    localparam logic [63:0] FNV_MULT  = 64'h00000100000001B3;

    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_ZERO     = 2'd3;

    localparam logic [2:0] LOG2_MAX = 3'd6;

endpackage

### src/chained_hash_map_u64_unit.sv
// sequence: the hash takes the key's 8 bytes in turn, each an xor (S_HASH) and 4
//   partial products (S_MUL); then the bucket head is read, the chain is walked with
//   a read and a compare per node, and a new-key insert or a remove behind the chain
//   head adds a write state; one transaction at a time, the next accepted in S_IDLE
// reset: a clearing pass over the node pool builds the free list and empties the
//   bucket heads while in_ready and cfg_ready stay low
module chained_hash_map_u64_unit import chm_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            cmd,
    input  logic [63:0]           key,
    input  logic [63:0]           write_value,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic [63:0]           read_value,
    output logic [CNT_W-1:0]      entry_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            log2_bucket_count
);

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_HASH   = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_HEAD   = 4'd4;
    localparam logic [3:0] S_LOADH  = 4'd5;
    localparam logic [3:0] S_RD     = 4'd6;
    localparam logic [3:0] S_CMP    = 4'd7;
    localparam logic [3:0] S_ACT    = 4'd8;
    localparam logic [3:0] S_INS    = 4'd9;
    localparam logic [3:0] S_RMP    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [2:0]        lg_reg;
    logic [1:0]        cmd_reg;
    logic [63:0]       key_reg, wv_reg;
    logic [63:0]       h_reg;
    logic [63:0]       acc_reg;
    logic [1:0]        part_reg;
    logic [2:0]        byte_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [LINK_W-1:0] head_reg, cur_reg, prev_reg, nx_reg;
    logic [63:0]       fv_reg;
    logic [CNT_W-1:0]  steps_reg;
    logic [NODE_W-1:0] clr_reg;
    logic [LINK_W-1:0] free_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [1:0]        st_reg;
    logic [63:0]       rv_reg;
    logic              ov_reg;
    logic [1:0]        out_st_reg;
    logic [63:0]       out_rv_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    // memories
    logic              k_we, v_we, l_we, hd_we;
    logic [NODE_W-1:0] k_wa, v_wa, l_wa, k_ra, v_ra, l_ra;
    logic [63:0]       k_wd, v_wd, k_rd, v_rd;
    logic [LINK_W-1:0] l_wd, l_rd;
    logic [BKT_W-1:0]  hd_wa, hd_ra;
    logic [LINK_W-1:0] hd_wd, hd_rd;

    chm_ram #(.WIDTH(64), .DEPTH(NODE_POOL_SIZE)) u_key (
        .clk(clk), .we(k_we), .waddr(k_wa), .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
    chm_ram #(.WIDTH(64), .DEPTH(NODE_POOL_SIZE)) u_val (
        .clk(clk), .we(v_we), .waddr(v_wa), .wdata(v_wd), .raddr(v_ra), .rdata(v_rd));
    chm_ram #(.WIDTH(LINK_W), .DEPTH(NODE_POOL_SIZE)) u_link (
        .clk(clk), .we(l_we), .waddr(l_wa), .wdata(l_wd), .raddr(l_ra), .rdata(l_rd));
    chm_ram #(.WIDTH(LINK_W), .DEPTH(MAX_BUCKETS)) u_head (
        .clk(clk), .we(hd_we), .waddr(hd_wa), .wdata(hd_wd), .raddr(hd_ra), .rdata(hd_rd));

    logic cur_ok, prev_ok;
    assign cur_ok  = (cur_reg < NIL_NODE);
    assign prev_ok = (prev_reg < NIL_NODE);

    // 64x16 partial product of the running hash
    logic [15:0] mult_part;
    logic [79:0] pp;
    logic [63:0] mul_sum;
    assign mult_part = FNV_MULT[{part_reg, 4'd0} +: 16];
    assign pp        = {16'd0, h_reg} * {64'd0, mult_part};
    assign mul_sum   = acc_reg + (pp[63:0] << {part_reg, 4'd0});

    // masked bucket from the final hash
    logic [2:0]       lg_eff;
    logic [BKT_W-1:0] bmask;
    logic [BKT_W-1:0] bkt_calc;
    assign lg_eff   = (lg_reg > LOG2_MAX) ? LOG2_MAX : lg_reg;
    assign bmask    = BKT_W'((64'd1 << lg_eff) - 64'd1);
    assign bkt_calc = mul_sum[BKT_W-1:0] & bmask;

    assign in_ready    = (state_reg == S_IDLE);
    assign cfg_ready   = (state_reg == S_IDLE);
    assign out_valid   = ov_reg;
    assign status      = out_st_reg;
    assign read_value  = out_rv_reg;
    assign entry_count = out_cnt_reg;

    // memory control and next state
    always_comb
    begin
        state_next = state_reg;
        k_we = 1'b0; v_we = 1'b0; l_we = 1'b0; hd_we = 1'b0;
        k_wa = cur_reg[NODE_W-1:0]; v_wa = cur_reg[NODE_W-1:0]; l_wa = cur_reg[NODE_W-1:0];
        k_wd = key_reg; v_wd = wv_reg; l_wd = free_reg;
        k_ra = cur_reg[NODE_W-1:0]; v_ra = cur_reg[NODE_W-1:0];
        l_ra = cur_reg[NODE_W-1:0];
        hd_wa = bkt_reg; hd_wd = NIL_NODE; hd_ra = bkt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                // node i links to i+1, bucket heads empty
                l_we  = 1'b1;
                l_wa  = clr_reg;
                l_wd  = LINK_W'(clr_reg) + LINK_W'(1);
                hd_we = (clr_reg < NODE_W'(MAX_BUCKETS));
                hd_wa = clr_reg[BKT_W-1:0];
                if (clr_reg == NODE_W'(NODE_POOL_SIZE - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (part_reg == 2'd3)
                begin
                    state_next = (byte_reg == 3'd7) ? S_HEAD : S_HASH;
                end
            end
            S_HEAD:
            begin
                // head read at bkt_reg
                state_next = S_LOADH;
            end
            S_LOADH:
            begin
                state_next = S_RD;
            end
            S_RD:
            begin
                // key, value and link of cur are read
                state_next = (cur_ok && (steps_reg < CNT_W'(NODE_POOL_SIZE))) ? S_CMP : S_ACT;
            end
            S_CMP:
            begin
                state_next = (k_rd == key_reg) ? S_ACT : S_RD;
            end
            S_ACT:
            begin
                state_next = S_OUT;
                if (cmd_reg == CMD_INSERT && wv_reg != 64'd0)
                begin
                    if (cur_ok)
                    begin
                        v_we = 1'b1;
                    end
                    else if (free_reg < NIL_NODE)
                    begin
                        // fetch next free node
                        l_ra = free_reg[NODE_W-1:0];
                        state_next = S_INS;
                    end
                end
                else if (cmd_reg == CMD_REMOVE && cur_ok)
                begin
                    // push cur on the free list; unlink at the head if cur has no predecessor
                    l_we = 1'b1;
                    if (prev_ok)
                    begin
                        state_next = S_RMP;
                    end
                    else
                    begin
                        hd_we = 1'b1;
                        hd_wd = nx_reg;
                    end
                end
            end
            S_INS:
            begin
                k_we = 1'b1; v_we = 1'b1; l_we = 1'b1; hd_we = 1'b1;
                k_wa = free_reg[NODE_W-1:0]; v_wa = free_reg[NODE_W-1:0];
                l_wa = free_reg[NODE_W-1:0]; l_wd = head_reg;
                hd_wd = free_reg;
                state_next = S_OUT;
            end
            S_RMP:
            begin
                // predecessor skips the removed node
                l_we = 1'b1;
                l_wa = prev_reg[NODE_W-1:0];
                l_wd = nx_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            free_reg    <= '0;
            count_reg   <= '0;
            lg_reg      <= LOG2_MAX;
            ov_reg      <= 1'b0;
            out_st_reg  <= ST_OK;
            out_rv_reg  <= '0;
            out_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                lg_reg <= log2_bucket_count;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + NODE_W'(1);
                end
                S_ACT:
                begin
                    if (cmd_reg == CMD_REMOVE && cur_ok)
                    begin
                        free_reg <= cur_reg;
                        if (count_reg != '0)
                        begin
                            count_reg <= count_reg - CNT_W'(1);
                        end
                    end
                end
                S_INS:
                begin
                    free_reg  <= l_rd;
                    count_reg <= count_reg + CNT_W'(1);
                end
                default:
                begin
                end
            endcase
            // output register
            if (state_reg == S_OUT && (!ov_reg || out_ready))
            begin
                ov_reg      <= 1'b1;
                out_st_reg  <= st_reg;
                out_rv_reg  <= rv_reg;
                out_cnt_reg <= count_reg;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cmd_reg  <= cmd;
                key_reg  <= key;
                wv_reg   <= write_value;
                h_reg    <= FNV_BASIS;
                byte_reg <= '0;
            end
            S_HASH:
            begin
                h_reg    <= h_reg ^ {56'd0, key_reg[{byte_reg, 3'd0} +: 8]};
                acc_reg  <= '0;
                part_reg <= '0;
            end
            S_MUL:
            begin
                acc_reg  <= mul_sum;
                part_reg <= part_reg + 2'd1;
                if (part_reg == 2'd3)
                begin
                    h_reg    <= mul_sum;
                    byte_reg <= byte_reg + 3'd1;
                    if (byte_reg == 3'd7)
                    begin
                        bkt_reg <= bkt_calc;
                    end
                end
            end
            S_LOADH:
            begin
                // chain walk starts at the bucket head
                head_reg  <= hd_rd;
                cur_reg   <= hd_rd;
                prev_reg  <= NIL_NODE;
                steps_reg <= '0;
            end
            S_RD:
            begin
                if (steps_reg >= CNT_W'(NODE_POOL_SIZE))
                begin
                    cur_reg <= NIL_NODE;
                end
            end
            S_CMP:
            begin
                if (k_rd == key_reg)
                begin
                    nx_reg <= l_rd;
                    fv_reg <= v_rd;
                end
                else
                begin
                    prev_reg  <= cur_reg;
                    cur_reg   <= l_rd;
                    steps_reg <= steps_reg + CNT_W'(1);
                end
            end
            S_ACT:
            begin
                case (cmd_reg)
                    CMD_LOOKUP:
                    begin
                        st_reg <= cur_ok ? ST_OK : ST_NOT_FOUND;
                        rv_reg <= cur_ok ? fv_reg : 64'd0;
                    end
                    CMD_INSERT:
                    begin
                        st_reg <= (wv_reg == 64'd0) ? ST_ZERO
                                : cur_ok ? ST_OK
                                : (free_reg < NIL_NODE) ? ST_OK : ST_FULL;
                        rv_reg <= '0;
                    end
                    CMD_REMOVE:
                    begin
                        st_reg <= cur_ok ? ST_OK : ST_NOT_FOUND;
                        rv_reg <= '0;
                    end
                    default:
                    begin
                        st_reg <= ST_NOT_FOUND;
                        rv_reg <= '0;
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

endmodule

### src/chm_ram.sv
module chm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
